FILE: hw/rtl/lef_pkg.sv
// lef_pkg: shared constants, types and codes for the 3x3 laplacian edge filter
// no dependencies; imported by lef_ctrl, lef_datapath and laplacian_edge_filter_3x3
package lef_pkg;

   // image limits and derived widths
   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT + 2);

   // register port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int DIM_W      = 12;
   localparam int GAIN_W     = 16;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FILTER_GAIN  = 2'd2;

   localparam logic [DIM_W-1:0]  RESET_WIDTH  = 12'd640;
   localparam logic [DIM_W-1:0]  RESET_HEIGHT = 12'd480;
   localparam logic [GAIN_W-1:0] RESET_GAIN   = 16'd256;

   // request kinds
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   // gray conversion weights, sum is 65536
   localparam logic [23:0] W_RED   = 24'd19595;
   localparam logic [23:0] W_GREEN = 24'd38470;
   localparam logic [23:0] W_BLUE  = 24'd7471;

   // arithmetic widths
   localparam int DIFF_W = 12;
   localparam int PROD_W = DIFF_W + GAIN_W + 1;

   // sequencer states
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_GRAY  = 6'b000010,
      ST_SHIFT = 6'b000100,
      ST_SUM   = 6'b001000,
      ST_MUL   = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic gray_step;
      logic shift_step;
      logic sum_step;
      logic mul_step;
      logic out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic pixel_due;
      logic emit;
      logic out_free;
   } status_type;

endpackage

FILE: hw/rtl/lef_ctrl.sv
// lef_ctrl: sequencer that steps one request through the edge datapath
// depends on lef_pkg
module lef_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_kind,
   input  lef_pkg::status_type status,
   output logic                req_stall,
   output lef_pkg::cmd_type    cmd
);
   import lef_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;
   logic      drop;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   // flush while pixels are still due has no effect at all
   assign drop      = (req_kind == KIND_FLUSH) && status.pixel_due;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept && !drop) state_in = ST_GRAY;
         ST_GRAY:  state_in = ST_SHIFT;
         ST_SHIFT: state_in = ST_SUM;
         ST_SUM:   state_in = status.emit ? ST_MUL : ST_IDLE;
         ST_MUL:   state_in = ST_OUT;
         ST_OUT:   if (status.out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // commands
   always_comb begin
      cmd            = '0;
      cmd.accept     = accept && !drop;
      cmd.gray_step  = (state_ff == ST_GRAY);
      cmd.shift_step = (state_ff == ST_SHIFT);
      cmd.sum_step   = (state_ff == ST_SUM);
      cmd.mul_step   = (state_ff == ST_MUL);
      cmd.out_load   = (state_ff == ST_OUT) && status.out_free;
   end

endmodule

FILE: hw/rtl/lef_datapath.sv
// lef_datapath: config registers, gray conversion, line memory, 3x3 window,
// laplacian sum, gain multiply, clamp and result register; depends on lef_pkg
module lef_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  lef_pkg::cmd_type                   cmd,
   output lef_pkg::status_type                status,
   input  logic                               req_kind,
   input  logic [7:0]                         req_red,
   input  logic [7:0]                         req_green,
   input  logic [7:0]                         req_blue,
   input  logic                               csr_wr_en,
   input  logic [lef_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lef_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [7:0]                         rsp_edge_value,
   output logic                               rsp_last_of_frame
);
   import lef_pkg::*;

   // config
   logic [DIM_W-1:0]  width_ff;
   logic [DIM_W-1:0]  height_ff;
   logic [GAIN_W-1:0] gain_ff;
   logic [DIM_W-1:0]  dim_clamped;
   logic              restart;

   // frame position
   logic [COL_W-1:0]  col_ff;
   logic [COL_W-1:0]  col_in;
   logic [ROW_W-1:0]  row_ff;
   logic [ROW_W-1:0]  row_in;
   logic [DIM_W:0]    col_next;

   // request and gray
   logic              pixel_ff;
   logic [7:0]        red_ff;
   logic [7:0]        green_ff;
   logic [7:0]        blue_ff;
   logic [23:0]       gray_sum;
   logic [7:0]        gray_ff;

   // line memory, {upper, middle}
   logic [15:0]       line_mem [MAX_WIDTH];
   logic [15:0]       line_rd_ff;

   // window, index row*3 + column, column 2 newest
   logic [7:0]        win_ff [9];

   // border flags for the pending result
   logic              emit_ff;
   logic              top_ff;
   logic              bot_ff;
   logic              left_ff;
   logic              right_ff;
   logic              last_ff;
   logic              emit_in;
   logic              top_in;
   logic              bot_in;
   logic              left_in;
   logic              right_in;

   // arithmetic
   logic [10:0]               nsum;
   logic signed [DIFF_W-1:0]  diff_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic [PROD_W-9:0]         quot;
   logic [7:0]                edge_in;

   // result register
   logic              rsp_valid_ff;
   logic [7:0]        rsp_edge_ff;
   logic              rsp_last_ff;

   // width and height clamp to 1..max on write
   always_comb begin
      dim_clamped = csr_wdata[DIM_W-1:0];
      if (csr_wdata[DIM_W-1:0] == '0) begin
         dim_clamped = DIM_W'(1);
      end else if (csr_index == REG_IMAGE_WIDTH &&
                   csr_wdata[DIM_W-1:0] > DIM_W'(MAX_WIDTH)) begin
         dim_clamped = DIM_W'(MAX_WIDTH);
      end else if (csr_index == REG_IMAGE_HEIGHT &&
                   csr_wdata[DIM_W-1:0] > DIM_W'(MAX_HEIGHT)) begin
         dim_clamped = DIM_W'(MAX_HEIGHT);
      end
   end

   assign restart = csr_wr_en &&
                    (csr_index == REG_IMAGE_WIDTH || csr_index == REG_IMAGE_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
         gain_ff   <= RESET_GAIN;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  width_ff  <= dim_clamped;
            REG_IMAGE_HEIGHT: height_ff <= dim_clamped;
            REG_FILTER_GAIN:  gain_ff   <= csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // request latch; a pixel after the frame's pixels counts as zero
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pixel_ff <= (req_kind == KIND_PIXEL) && status.pixel_due;
         red_ff   <= req_red;
         green_ff <= req_green;
         blue_ff  <= req_blue;
      end
   end

   // gray conversion and line memory read
   assign gray_sum = W_RED * 24'(red_ff) + W_GREEN * 24'(green_ff) + W_BLUE * 24'(blue_ff);

   always_ff @(posedge clock) begin
      if (cmd.gray_step) begin
         gray_ff    <= pixel_ff ? gray_sum[23:16] : 8'd0;
         line_rd_ff <= line_mem[col_ff];
      end
      if (cmd.shift_step) begin
         line_mem[col_ff] <= {line_rd_ff[7:0], gray_ff};
      end
   end

   // output position and borders, taken from the counters before they advance
   always_comb begin
      emit_in  = !(row_ff == '0 || (row_ff == ROW_W'(1) && col_ff == '0));
      right_in = (col_ff == '0);
      left_in  = (col_ff == COL_W'(1)) || (col_ff == '0 && width_ff == DIM_W'(1));
      top_in   = (col_ff == '0) ? (row_ff == ROW_W'(2)) : (row_ff == ROW_W'(1));
      bot_in   = (col_ff == '0) ? (row_ff == ROW_W'(height_ff) + ROW_W'(1))
                                : (row_ff == ROW_W'(height_ff));
   end

   // column and row counters
   always_comb begin
      col_next = (DIM_W+1)'(col_ff) + (DIM_W+1)'(1);
      col_in   = col_ff;
      row_in   = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (cmd.shift_step) begin
         if (emit_in && right_in && bot_in) begin
            col_in = '0;
            row_in = '0;
         end else if (col_next >= (DIM_W+1)'(width_ff)) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_next[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_ff <= 1'b0;
         last_ff <= 1'b0;
      end else if (cmd.shift_step) begin
         emit_ff <= emit_in;
         last_ff <= emit_in && right_in && bot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.shift_step) begin
         top_ff   <= top_in;
         bot_ff   <= bot_in;
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

   // window shift, clear on restart or after the frame's last result
   always_ff @(posedge clock) begin
      if (reset || restart || (cmd.sum_step && last_ff)) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= 8'd0;
         end
      end else if (cmd.shift_step) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2] <= line_rd_ff[15:8];
         win_ff[3] <= win_ff[4];
         win_ff[4] <= win_ff[5];
         win_ff[5] <= line_rd_ff[7:0];
         win_ff[6] <= win_ff[7];
         win_ff[7] <= win_ff[8];
         win_ff[8] <= gray_ff;
      end
   end

   // neighbor sum with zero padding
   always_comb begin
      nsum = '0;
      if (!top_ff) begin
         if (!left_ff)  nsum = nsum + 11'(win_ff[0]);
         nsum = nsum + 11'(win_ff[1]);
         if (!right_ff) nsum = nsum + 11'(win_ff[2]);
      end
      if (!left_ff)  nsum = nsum + 11'(win_ff[3]);
      if (!right_ff) nsum = nsum + 11'(win_ff[5]);
      if (!bot_ff) begin
         if (!left_ff)  nsum = nsum + 11'(win_ff[6]);
         nsum = nsum + 11'(win_ff[7]);
         if (!right_ff) nsum = nsum + 11'(win_ff[8]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sum_step) begin
         diff_ff <= $signed({1'b0, win_ff[4], 3'b000}) - $signed({1'b0, nsum});
      end
      if (cmd.mul_step) begin
         prod_ff <= PROD_W'(diff_ff) * $signed({1'b0, gain_ff});
      end
   end

   // floor by 256 and clamp to 0..255
   assign quot = prod_ff[PROD_W-1:8];

   always_comb begin
      if (prod_ff <= 0) begin
         edge_in = 8'd0;
      end else if (quot > (PROD_W-8)'(255)) begin
         edge_in = 8'd255;
      end else begin
         edge_in = quot[7:0];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_edge_ff <= edge_in;
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_edge_value    = rsp_edge_ff;
   assign rsp_last_of_frame = rsp_last_ff;

   // status
   assign status.pixel_due = (row_ff < ROW_W'(height_ff));
   assign status.emit      = emit_ff;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

endmodule

FILE: hw/rtl/laplacian_edge_filter_3x3.sv
// laplacian_edge_filter_3x3: top level, RGB pixel stream in, edge values out
// depends on lef_pkg, lef_ctrl, lef_datapath
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   kind, red, green, blue
//   rsp_      out        rsp_valid/rsp_stall   edge_value, last_of_frame
//   csr_      in         csr_wr_en             csr_index, csr_wdata
//
// a request without a result goes back to idle after the sum step, and a flush
// while pixels are still due is dropped in idle; the sequencer walks one request
// at a time through gray, line memory, sum, multiply and result steps
// the result register lets the next request start while a result is stalled
// reset is synchronous; no memory clearing pass, line memory is masked by
// the border logic until written
module laplacian_edge_filter_3x3 (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_kind,
   input  logic [7:0]                        req_red,
   input  logic [7:0]                        req_green,
   input  logic [7:0]                        req_blue,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [7:0]                        rsp_edge_value,
   output logic                              rsp_last_of_frame,
   input  logic                              csr_wr_en,
   input  logic [lef_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lef_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import lef_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer
   lef_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   // datapath
   lef_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_kind          (req_kind),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_edge_value    (rsp_edge_value),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule
